// ----- sv/drg_pkg.sv -----
// shared types and constants for the depth region grow block
package drg_pkg;

  // frame size; pixel addresses are {y, x}
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;
  localparam logic [1:0] CFG_TOPK   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_RD,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE_SEG,
    ST_RANK,
    ST_RESULT,
    ST_READ_RD,
    ST_READ_CHK
  } state_e;

  // neighbour offsets in growth order
  localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1,
                                                2'sd1, 2'sd1, -2'sd1, -2'sd1};

endpackage

// ----- sv/depth_region_grow_topk_top.sv -----
// depth region growing segmentation with top-k ranking
// s_axis carries requests, tuser holding the kind: write a depth pixel, run
// segmentation, or read a pixel. m_axis carries one result for each run or read
// request, tuser set for a run result; writes give none.
// a write is taken every cycle while the block is idle and holds no result. a
// read registers its result after a label memory read, then a size memory read
// and top-k compare. a run first clears the label memory, one entry a cycle,
// then scans in-use pixels column-major, each scanned pixel with a read and a
// check step; each grown pixel is popped from the stack and its depth read, then
// each of its eight neighbours is read and checked. each segment ends with an
// empty pop, a size write and a top-k insert walk down the ranking, after which
// the scan goes on; the result is registered once the scan ends.
// one request is in work at a time; the next is taken once the result has left
// the output register. a stalled receiver holds the result and the block waits.
// reset sets the registers to their defaults (width 128, height 128, threshold
// 16, top count 4), empties the ranking and sets the segment count to zero;
// reads before any run answer unlabeled. the depth memory is undefined until
// written.
module depth_region_grow_topk_top #(
  parameter int MAX_TOP    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // pix_x[6:0], pix_y[13:7], depth_value[29:14], zero fill [31:30]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // is_run_result[0]
  output logic        m_axis_tuser,
  // segment_count[14:0], labeled[15], in_top[16], segment_rank[20:17],
  // segment_size[35:21], zero fill [39:36]
  output logic [39:0] m_axis_tdata
);
  import drg_pkg::*;

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = XW + YW;
  localparam int TW   = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int KW   = $clog2(MAX_TOP + 1);

  // memories
  logic [15:0]   depth_mem [NPIX];
  logic [AW:0]   label_mem [NPIX];
  logic [AW-1:0] stack_mem [NPIX];
  logic [AW:0]   size_mem  [NPIX];

  logic [14:0] top_size_q [MAX_TOP];
  logic [AW:0] top_lab_q  [MAX_TOP];
  logic [KW-1:0] top_valid_q;

  logic [7:0]  width_q, height_q;
  logic [14:0] thresh_q;
  logic [4:0]  topk_q;

  state_e state_q, state_d;

  logic [AW:0]   cnt_q;
  logic [XW:0]   sx_q;
  logic [YW:0]   sy_q;
  logic [AW:0]   sp_q;
  logic [AW:0]   found_q;
  logic [AW:0]   seg_size_q;
  logic [XW-1:0] px_q;
  logic [YW-1:0] py_q;
  logic [15:0]   pd_q;
  logic [2:0]    dir_q;
  logic [AW-1:0] nb_q;
  logic [KW-1:0] pos_q;
  logic [AW:0]   rd_lab_q;
  logic          rd_in_q;
  logic          ran_q;

  logic [15:0] depth_rd_q;
  logic [AW:0] label_rd_q;
  logic [AW-1:0] stack_rd_q;
  logic [AW:0] size_rd_q;

  logic        out_valid_q;
  logic        out_user_q;
  logic [39:0] out_data_q;

  // request fields
  logic [1:0]  req;
  logic [6:0]  rx, ry;
  logic [15:0] rdepth;
  assign req    = s_axis_tuser;
  assign rx     = s_axis_tdata[6:0];
  assign ry     = s_axis_tdata[13:7];
  assign rdepth = s_axis_tdata[29:14];

  logic req_fire;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign req_fire      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  // saturated in-use area
  logic [XW:0] w_eff;
  logic [YW:0] h_eff;
  logic [KW-1:0] k_eff;
  always_comb begin
    w_eff = (32'(width_q) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(width_q);
    h_eff = (32'(height_q) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(height_q);
    k_eff = (32'(topk_q) > MAX_TOP) ? KW'(MAX_TOP) : KW'(topk_q);
  end

  logic rx_in, ry_in;
  assign rx_in = 32'(rx) < MAX_WIDTH;
  assign ry_in = 32'(ry) < MAX_HEIGHT;

  // neighbour coordinate
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic nb_ok;
  always_comb begin
    nx = $signed({2'b00, px_q}) + (XW+2)'(STEP_DX[dir_q]);
    ny = $signed({2'b00, py_q}) + (YW+2)'(STEP_DY[dir_q]);
    nb_ok = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, w_eff}))
            && (ny < $signed({1'b0, h_eff}));
  end

  logic [16:0] dabs;
  logic signed [16:0] ddiff;
  always_comb begin
    ddiff = $signed({depth_rd_q[15], depth_rd_q}) - $signed({pd_q[15], pd_q});
    dabs  = ddiff[16] ? 17'(-ddiff) : 17'(ddiff);
  end

  logic [AW-1:0] seed_addr;
  assign seed_addr = {sy_q[YW-1:0], sx_q[XW-1:0]};

  // memory port control
  logic          dm_we, lm_we, sm_we, zm_we;
  logic [AW-1:0] dm_addr, lm_addr, sm_addr, zm_addr;
  logic [AW:0]   lm_wd, zm_wd;
  logic [AW-1:0] sm_wd;

  // top-k insertion step
  logic rank_last;
  logic [KW-1:0] rank_lim;
  assign rank_lim  = (top_valid_q < k_eff) ? top_valid_q : KW'(k_eff - 1'b1);

  always_comb begin
    state_d = state_q;
    dm_we = 1'b0; dm_addr = {ry[YW-1:0], rx[XW-1:0]};
    lm_we = 1'b0; lm_addr = cnt_q[AW-1:0]; lm_wd = '0;
    sm_we = 1'b0; sm_addr = sp_q[AW-1:0]; sm_wd = nb_q;
    zm_we = 1'b0; zm_addr = found_q[AW-1:0]; zm_wd = seg_size_q;
    rank_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req)
            REQ_WRITE: dm_we = rx_in && ry_in;
            REQ_RUN:   state_d = ST_CLEAR;
            REQ_READ:  state_d = ST_READ_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        lm_we = 1'b1;
        if (cnt_q == (AW+1)'(NPIX - 1)) begin
          state_d = (w_eff == 0 || h_eff == 0) ? ST_RESULT : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        dm_addr = seed_addr; lm_addr = seed_addr;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (label_rd_q == 0 && depth_rd_q != 0) begin
          lm_we = 1'b1; lm_addr = seed_addr; lm_wd = found_q + 1'b1;
          sm_we = 1'b1; sm_addr = '0; sm_wd = seed_addr;
          state_d = ST_POP;
        end else if (sy_q + 1'b1 < h_eff) begin
          state_d = ST_SCAN_RD;
        end else if (sx_q + 1'b1 < w_eff) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_POP: begin
        if (sp_q == 0) begin
          state_d = ST_DONE_SEG;
        end else begin
          sm_addr = AW'(sp_q - 1'b1);
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        dm_addr = stack_rd_q;
        state_d = ST_NB_RD;
      end
      ST_NB_RD: begin
        dm_addr = {ny[YW-1:0], nx[XW-1:0]};
        lm_addr = {ny[YW-1:0], nx[XW-1:0]};
        state_d = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        if (nb_ok && label_rd_q == 0 && dabs < 17'(thresh_q)) begin
          lm_we = 1'b1; lm_addr = nb_q; lm_wd = found_q;
          sm_we = 1'b1;
        end
        state_d = (dir_q == 3'd7) ? ST_POP : ST_NB_RD;
      end
      ST_DONE_SEG: begin
        zm_we = 1'b1; zm_addr = AW'(found_q - 1'b1);
        state_d = ST_RANK;
      end
      ST_RANK: begin
        if (pos_q == 0 || top_size_q[TW'(pos_q - 1'b1)] >= 15'(seg_size_q)) begin
          rank_last = 1'b1;
          if (sy_q + 1'b1 < h_eff || sx_q + 1'b1 < w_eff) state_d = ST_SCAN_RD;
          else state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      ST_READ_RD: begin
        zm_addr = AW'(label_rd_q - 1'b1);
        state_d = ST_READ_CHK;
      end
      ST_READ_CHK: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // synchronous memories
  always_ff @(posedge clk_i) begin
    if (dm_we) depth_mem[dm_addr] <= rdepth;
    depth_rd_q <= depth_mem[dm_addr];
  end
  always_ff @(posedge clk_i) begin
    if (lm_we) label_mem[lm_addr] <= lm_wd;
    if (state_q == ST_IDLE) label_rd_q <= label_mem[{ry[YW-1:0], rx[XW-1:0]}];
    else label_rd_q <= label_mem[lm_addr];
  end
  always_ff @(posedge clk_i) begin
    if (sm_we) stack_mem[sm_addr] <= sm_wd;
    stack_rd_q <= stack_mem[sm_addr];
  end
  always_ff @(posedge clk_i) begin
    if (zm_we) size_mem[zm_addr] <= zm_wd;
    size_rd_q <= size_mem[zm_addr];
  end

  // in-top lookup for reads
  logic hit;
  logic [3:0] hit_rank;
  always_comb begin
    hit = 1'b0; hit_rank = '0;
    for (int i = MAX_TOP - 1; i >= 0; i--) begin
      if (KW'(i) < top_valid_q && top_lab_q[i] == rd_lab_q) begin
        hit = 1'b1; hit_rank = 4'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      width_q <= 8'd128; height_q <= 8'd128;
      thresh_q <= 15'd16; topk_q <= 5'd4;
      top_valid_q <= '0; found_q <= '0;
      out_valid_q <= 1'b0; out_user_q <= 1'b0; out_data_q <= '0;
      cnt_q <= '0; sx_q <= '0; sy_q <= '0; sp_q <= '0;
      dir_q <= '0; pos_q <= '0; seg_size_q <= '0;
      rd_lab_q <= '0; rd_in_q <= 1'b0; ran_q <= 1'b0;
      for (int i = 0; i < MAX_TOP; i++) begin
        top_size_q[i] <= '0; top_lab_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  <= cfg_data_i[7:0];
          CFG_HEIGHT: height_q <= cfg_data_i[7:0];
          CFG_THRESH: thresh_q <= cfg_data_i;
          CFG_TOPK:   topk_q   <= cfg_data_i[4:0];
          default:    ;
        endcase
      end
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          rd_in_q <= rx_in && ry_in;
          if (req_fire && req == REQ_RUN) begin
            ran_q <= 1'b1;
            top_valid_q <= '0; found_q <= '0; sx_q <= '0; sy_q <= '0;
            for (int i = 0; i < MAX_TOP; i++) begin
              top_size_q[i] <= '0; top_lab_q[i] <= '0;
            end
          end
        end
        ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        ST_SCAN_CHK: begin
          if (label_rd_q == 0 && depth_rd_q != 0) begin
            found_q <= found_q + 1'b1; sp_q <= 1; seg_size_q <= 1;
          end else if (sy_q + 1'b1 < h_eff) begin
            sy_q <= sy_q + 1'b1;
          end else begin
            sy_q <= '0; sx_q <= sx_q + 1'b1;
          end
        end
        ST_POP: if (sp_q != 0) sp_q <= sp_q - 1'b1;
        ST_POP_RD: begin
          px_q <= stack_rd_q[XW-1:0]; py_q <= stack_rd_q[AW-1:XW];
          dir_q <= '0;
        end
        ST_NB_RD: begin
          pd_q <= (dir_q == 0) ? depth_rd_q : pd_q;
          nb_q <= {ny[YW-1:0], nx[XW-1:0]};
        end
        ST_NB_CHK: begin
          dir_q <= dir_q + 1'b1;
          if (nb_ok && label_rd_q == 0 && dabs < 17'(thresh_q)) begin
            sp_q <= sp_q + 1'b1; seg_size_q <= seg_size_q + 1'b1;
          end
        end
        ST_DONE_SEG: pos_q <= top_valid_q;
        ST_RANK: begin
          if (rank_last) begin
            if (pos_q < k_eff) begin
              for (int i = 1; i < MAX_TOP; i++) begin
                if (KW'(i) > pos_q && KW'(i) <= rank_lim) begin
                  top_size_q[i] <= top_size_q[i-1]; top_lab_q[i] <= top_lab_q[i-1];
                end
              end
              top_size_q[TW'(pos_q)] <= 15'(seg_size_q);
              top_lab_q[TW'(pos_q)]  <= found_q;
              if (top_valid_q < k_eff) top_valid_q <= top_valid_q + 1'b1;
            end
            if (sy_q + 1'b1 < h_eff) sy_q <= sy_q + 1'b1;
            else begin
              sy_q <= '0; sx_q <= sx_q + 1'b1;
            end
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        ST_RESULT: begin
          out_valid_q <= 1'b1;
          out_user_q  <= 1'b1;
          out_data_q  <= {4'b0, 15'd0, 4'd0, 1'b0, 1'b0, 15'(found_q)};
        end
        // labels are only meaningful once a run has cleared the label memory
        ST_READ_RD: rd_lab_q <= (rd_in_q && ran_q) ? label_rd_q : '0;
        ST_READ_CHK: begin
          out_valid_q <= 1'b1;
          out_user_q  <= 1'b0;
          out_data_q  <= {4'b0,
                          (rd_lab_q != 0) ? 15'(size_rd_q) : 15'd0,
                          (rd_lab_q != 0 && hit) ? hit_rank : 4'd0,
                          rd_lab_q != 0 && hit,
                          rd_lab_q != 0,
                          15'(found_q)};
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- bench/testbench.sv -----
// testbench for the depth region grow top-k block
`timescale 1ns / 1ps

module testbench;
  import drg_pkg::*;

  localparam int FRAME_W = 128;
  localparam int FRAME_H = 128;
  localparam int NPIX    = FRAME_W * FRAME_H;
  localparam int TOP_MAX = 16;

  // request kind that the block ignores
  localparam logic [1:0] REQ_BAD = 2'd3;

  // predictor and store of expected results
  class segment_scoreboard;
    logic [15:0] depth_mem [NPIX];
    int unsigned label_mem [NPIX];
    int unsigned seg_size [NPIX];
    int unsigned top_size [TOP_MAX];
    int unsigned top_label [TOP_MAX];
    int unsigned top_used;
    int unsigned seg_found;
    int unsigned width_reg, height_reg, thresh_reg, topk_reg;
    // {tdata, tuser} of each expected result
    logic [40:0] expected_q [$];
    int errors;

    function new();
      foreach (label_mem[i]) label_mem[i] = 0;
      foreach (depth_mem[i]) depth_mem[i] = '0;
      top_used   = 0;
      seg_found  = 0;
      width_reg  = 128;
      height_reg = 128;
      thresh_reg = 16;
      topk_reg   = 4;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        CFG_WIDTH:  width_reg  = val[7:0];
        CFG_HEIGHT: height_reg = val[7:0];
        CFG_THRESH: thresh_reg = val;
        CFG_TOPK:   topk_reg   = val[4:0];
        default: ;
      endcase
    endfunction

    function void rank_segment(int unsigned lab, int unsigned sz, int unsigned k);
      int unsigned pos, i;
      pos = top_used;
      while (pos > 0 && top_size[pos-1] < sz) pos--;
      if (pos >= k) return;
      i = (top_used < k) ? top_used : k - 1;
      for (; i > pos; i--) begin
        top_size[i]  = top_size[i-1];
        top_label[i] = top_label[i-1];
      end
      top_size[pos]  = sz;
      top_label[pos] = lab;
      if (top_used < k) top_used++;
    endfunction

    function void segment_frame();
      int unsigned w, h, k, lab, sz, p, n, seed;
      int px, py, nx, ny, dp, diff;
      int unsigned grow_q [$];
      w = (width_reg > FRAME_W) ? FRAME_W : width_reg;
      h = (height_reg > FRAME_H) ? FRAME_H : height_reg;
      k = (topk_reg > TOP_MAX) ? TOP_MAX : topk_reg;
      foreach (label_mem[i]) label_mem[i] = 0;
      foreach (top_size[i]) begin
        top_size[i]  = 0;
        top_label[i] = 0;
      end
      top_used  = 0;
      seg_found = 0;
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) begin
          seed = y * FRAME_W + x;
          if (label_mem[seed] != 0 || depth_mem[seed] == 0) continue;
          seg_found++;
          lab = seg_found;
          label_mem[seed] = lab;
          grow_q.insert(grow_q.size(), seed);
          sz = 1;
          while (grow_q.size() > 0) begin
            p  = grow_q.pop_back();
            px = p % FRAME_W;
            py = p / FRAME_W;
            dp = $signed(depth_mem[p]);
            for (int d = 0; d < 8; d++) begin
              nx = px + STEP_DX[d];
              ny = py + STEP_DY[d];
              if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
              n = ny * FRAME_W + nx;
              if (label_mem[n] != 0) continue;
              diff = $signed(depth_mem[n]) - dp;
              if (diff < 0) diff = -diff;
              if (diff >= thresh_reg) continue;
              label_mem[n] = lab;
              grow_q.insert(grow_q.size(), n);
              sz++;
            end
          end
          seg_size[lab-1] = sz;
          rank_segment(lab, sz, k);
        end
      end
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] data);
      int unsigned idx, lab;
      logic [14:0] sz;
      logic [3:0]  rank;
      logic        hit;
      idx  = data[13:7] * FRAME_W + data[6:0];
      if (kind == REQ_WRITE) begin
        depth_mem[idx] = data[29:14];
      end else if (kind == REQ_RUN) begin
        segment_frame();
        expected_q.insert(expected_q.size(),
                          {4'b0, 15'd0, 4'd0, 1'b0, 1'b0, seg_found[14:0], 1'b1});
      end else if (kind == REQ_READ) begin
        lab  = label_mem[idx];
        sz   = '0;
        rank = '0;
        hit  = 1'b0;
        if (lab != 0) begin
          sz = 15'(seg_size[lab-1]);
          for (int i = 0; i < top_used; i++) begin
            if (top_label[i] == lab) begin
              hit  = 1'b1;
              rank = 4'(i);
              break;
            end
          end
        end
        expected_q.insert(expected_q.size(),
                          {4'b0, sz, rank, hit, lab != 0, seg_found[14:0], 1'b0});
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(logic user, logic [39:0] data);
      logic [40:0] exp_r;
      logic [40:0] got;
      got = {data, user};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("is_run_result", exp_r[0], got[0]);
      compare_field("segment_count", exp_r[15:1], got[15:1]);
      compare_field("labeled", exp_r[16], got[16]);
      compare_field("in_top", exp_r[17], got[17]);
      compare_field("segment_rank", exp_r[21:18], got[21:18]);
      compare_field("segment_size", exp_r[36:22], got[36:22]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tuser;
  logic [39:0] m_axis_tdata;

  segment_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int fill_base;

  depth_region_grow_topk_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i)
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] kind, logic [6:0] x, logic [6:0] y, logic [15:0] dv);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b0, dv, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, {2'b0, dv, y, x});
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic configure(int w, int h, int thr, int k);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_WIDTH;  cfg_data_i <= 15'(w);
    sb.set_reg(CFG_WIDTH, 15'(w));
    @(negedge clk_i);
    cfg_idx_i <= CFG_HEIGHT; cfg_data_i <= 15'(h);
    sb.set_reg(CFG_HEIGHT, 15'(h));
    @(negedge clk_i);
    cfg_idx_i <= CFG_THRESH; cfg_data_i <= 15'(thr);
    sb.set_reg(CFG_THRESH, 15'(thr));
    @(negedge clk_i);
    cfg_idx_i <= CFG_TOPK; cfg_data_i <= 15'(k);
    sb.set_reg(CFG_TOPK, 15'(k));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // blocky depth pattern so that segments of several sizes appear
  function automatic logic [15:0] pattern_depth(int x, int y);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'h7fff;
    return 16'(fill_base + ((x / 3 + y / 2) % 4) * 700 + $urandom_range(0, 30));
  endfunction

  task automatic fill_area(int w, int h);
    for (int x = 0; x < w && x < FRAME_W; x++)
      for (int y = 0; y < h && y < FRAME_H; y++)
        send(REQ_WRITE, 7'(x), 7'(y), pattern_depth(x, y));
  endtask

  task automatic random_mix(int n, int w, int h);
    int r, x, y;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      x = $urandom_range(0, (w > 0 && w <= FRAME_W) ? w - 1 : FRAME_W - 1);
      y = $urandom_range(0, (h > 0 && h <= FRAME_H) ? h - 1 : FRAME_H - 1);
      if (r < 40) send(REQ_WRITE, 7'(x), 7'(y), pattern_depth(x, y));
      else if (r < 48) send(REQ_WRITE, 7'($urandom), 7'($urandom), 16'($urandom));
      else if (r < 85) send(REQ_READ, 7'(x), 7'(y), 16'($urandom));
      else if (r < 90) send(REQ_READ, 7'($urandom), 7'($urandom), 16'($urandom));
      else if (r < 95) send(REQ_RUN, 7'($urandom), 7'($urandom), 16'($urandom));
      else send(REQ_BAD, 7'($urandom), 7'($urandom), 16'($urandom));
    end
  endtask

  task automatic phase(int w, int h, int thr, int k, int fw, int fh, int n);
    drain();
    configure(w, h, thr, k);
    fill_base = $urandom_range(1, 20000);
    fill_area(fw, fh);
    send(REQ_RUN, '0, '0, '0);
    random_mix(n, w, h);
    send(REQ_RUN, '0, '0, '0);
    for (int i = 0; i < 6; i++)
      send(REQ_READ, 7'($urandom_range(0, 11)), 7'($urandom_range(0, 11)), '0);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    // reads before any run answer unlabeled
    send(REQ_READ, '0, '0, '0);
    send(REQ_READ, 7'd127, 7'd127, 16'hffff);
    send(REQ_BAD, 7'd5, 7'd5, 16'h1234);
    phase(8, 8, 16, 4, 8, 8, 20);
    // extremes of the depth field and corner pixel
    send(REQ_WRITE, 7'd127, 7'd127, 16'h8000);
    send(REQ_WRITE, 7'd0, 7'd0, 16'h7fff);
    send(REQ_READ, 7'd127, 7'd127, '0);
    phase(128, 1, 32767, 16, 128, 1, 15);
    phase(200, 1, 1000, 31, 0, 0, 10);
    phase(1, 64, 0, 1, 1, 64, 10);
    phase(0, 5, 100, 0, 0, 0, 10);
    phase(12, 6, 2000, 3, 12, 6, 20);
    phase(6, 5, 50, 16, 0, 0, 15);
    quiet = 1'b1;
    phase(10, 4, 800, 2, 10, 4, 20);
    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("testbench failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/drg_pkg.sv
sv/depth_region_grow_topk_top.sv
bench/testbench.sv
